// ===== rtl/cdw_pkg.sv =====
// cdw_pkg: widths, opcodes, month tables, stage structs and date helper functions
// shared by the calendar date / weekday / iso week core; depends on nothing
package cdw_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 13;
  localparam int WDAY_W = 3;
  localparam int WEEK_W = 6;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_FWD  = 2'd1;
  localparam logic [OP_W-1:0] OP_BACK = 2'd2;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  localparam logic [2:0] MONTH_SHIFT [12] = '{
    3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5
  };
  localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [WEEK_W-1:0] MONTH_WEEKS [12] = '{
    6'd0, 6'd4, 6'd8, 6'd12, 6'd17, 6'd21, 6'd25, 6'd30, 6'd34, 6'd39, 6'd43, 6'd47
  };

  typedef struct packed {
    logic              ok;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic              leap;
  } date_t;

  typedef struct packed {
    date_t      date;
    logic [6:0] yy;
    logic [1:0] cent;
  } split_t;

  typedef struct packed {
    date_t      date;
    logic       leap_prev;
    logic [2:0] yoff;
  } yinfo_t;

  // month code to table index, out-of-range months map to january
  function automatic logic [3:0] mix(input logic [MON_W-1:0] m);
    return (m >= MON_JAN && m <= MON_DEC) ? 4'(m - MON_JAN) : 4'd0;
  endfunction

  // divisible by 400 means divisible by 16 and by 25
  function automatic logic leap_of(input logic [YEAR_W-1:0] y);
    logic [25:0] p;
    logic [8:0]  q25;
    logic        div25;
    p     = 26'(y) * 26'd5243;
    q25   = p[25:17];
    div25 = (y == 13'(14'(q25) * 14'd25));
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] n;
    n = MONTH_DAYS[mix(m)];
    if (m == MON_FEB && leap) begin
      n = 5'd29;
    end
    return n;
  endfunction

  // residue mod 7 by folding octal digits, 8 = 1 mod 7
  function automatic logic [2:0] mod7(input logic [8:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

// ===== rtl/cdw_in_if.sv =====
// cdw_in_if: command channel of the date core, valid/ready plus opcode and load date
// depends on cdw_pkg for field widths
interface cdw_in_if;
  import cdw_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DAY_W-1:0]  day_in;
  logic [MON_W-1:0]  month_in;
  logic [YEAR_W-1:0] year_in;

  modport source (output valid, output opcode, output day_in, output month_in,
                  output year_in, input ready);
  modport sink   (input valid, input opcode, input day_in, input month_in,
                  input year_in, output ready);
endinterface

// ===== rtl/cdw_out_if.sv =====
// cdw_out_if: result channel of the date core, valid/ready plus date, weekday and week
// depends on cdw_pkg for field widths
interface cdw_out_if;
  import cdw_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [DAY_W-1:0]  day_out;
  logic [MON_W-1:0]  month_out;
  logic [YEAR_W-1:0] year_out;
  logic              leap_year;
  logic [WDAY_W-1:0] weekday;
  logic [WEEK_W-1:0] iso_week;

  modport source (output valid, output ok, output day_out, output month_out,
                  output year_out, output leap_year, output weekday, output iso_week,
                  input ready);
  modport sink   (input valid, input ok, input day_out, input month_out,
                  input year_out, input leap_year, input weekday, input iso_week,
                  output ready);
endinterface

// ===== rtl/cdw_date_step.sv =====
// cdw_date_step: stored date registers, load check and one-day steps, first pipeline stage
// depends on cdw_pkg and cdw_in_if
module cdw_date_step #(
  parameter int unsigned MAX_YEAR = 7999
) (
  input  logic           clk,
  input  logic           rst_n,
  cdw_in_if.sink         in_ch,
  output cdw_pkg::date_t dn_data,
  output logic           dn_valid,
  input  logic           dn_ready
);
  import cdw_pkg::*;

  localparam logic [YEAR_W-1:0] YEAR_LIM = YEAR_W'(MAX_YEAR);

  logic [DAY_W-1:0]  day_r, day_nxt;
  logic [MON_W-1:0]  month_r, month_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic              leap_r, leap_nxt;
  logic              ok_nxt;
  logic              s1_v_r;
  date_t             s1_r;

  logic              acc;
  logic [YEAR_W-1:0] year_cand;
  logic              cand_leap;
  logic [DAY_W-1:0]  cur_len;
  logic [DAY_W-1:0]  prev_len;
  logic              ld_ok;

  assign in_ch.ready = !s1_v_r || dn_ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign dn_valid    = s1_v_r;
  assign dn_data     = s1_r;

  assign cur_len  = month_len(month_r, leap_r);
  assign prev_len = month_len(month_r - 4'd1, leap_r);

  // one leap unit serves the load year and the year after or before a rollover
  always_comb begin
    if (in_ch.opcode == OP_LOAD) begin
      year_cand = in_ch.year_in;
    end else if (in_ch.opcode == OP_BACK) begin
      year_cand = year_r - 13'd1;
    end else begin
      year_cand = year_r + 13'd1;
    end
  end
  assign cand_leap = leap_of(year_cand);

  assign ld_ok = (in_ch.month_in >= MON_JAN) && (in_ch.month_in <= MON_DEC) &&
                 (in_ch.year_in <= YEAR_LIM) && (in_ch.day_in != 5'd0) &&
                 (in_ch.day_in <= month_len(in_ch.month_in, cand_leap));

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    leap_nxt  = leap_r;
    ok_nxt    = 1'b0;
    unique case (in_ch.opcode)
      OP_LOAD: begin
        if (ld_ok) begin
          day_nxt   = in_ch.day_in;
          month_nxt = in_ch.month_in;
          year_nxt  = in_ch.year_in;
          leap_nxt  = cand_leap;
          ok_nxt    = 1'b1;
        end
      end
      OP_FWD: begin
        if (day_r < cur_len) begin
          day_nxt = day_r + 5'd1;
          ok_nxt  = 1'b1;
        end else if (month_r < MON_DEC) begin
          day_nxt   = 5'd1;
          month_nxt = month_r + 4'd1;
          ok_nxt    = 1'b1;
        end else if (year_r < YEAR_LIM) begin
          day_nxt   = 5'd1;
          month_nxt = MON_JAN;
          year_nxt  = year_cand;
          leap_nxt  = cand_leap;
          ok_nxt    = 1'b1;
        end
      end
      OP_BACK: begin
        if (day_r > 5'd1) begin
          day_nxt = day_r - 5'd1;
          ok_nxt  = 1'b1;
        end else if (month_r > MON_JAN) begin
          month_nxt = month_r - 4'd1;
          day_nxt   = prev_len;
          ok_nxt    = 1'b1;
        end else if (year_r != 13'd0) begin
          day_nxt   = 5'd31;
          month_nxt = MON_DEC;
          year_nxt  = year_cand;
          leap_nxt  = cand_leap;
          ok_nxt    = 1'b1;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= 5'd1;
      month_r <= MON_JAN;
      year_r  <= 13'd2000;
      leap_r  <= 1'b1;
      s1_v_r  <= 1'b0;
    end else begin
      if (acc) begin
        day_r   <= day_nxt;
        month_r <= month_nxt;
        year_r  <= year_nxt;
        leap_r  <= leap_nxt;
      end
      if (in_ch.ready) begin
        s1_v_r <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.ok    <= ok_nxt;
      s1_r.day   <= day_nxt;
      s1_r.month <= month_nxt;
      s1_r.year  <= year_nxt;
      s1_r.leap  <= leap_nxt;
    end
  end

  a_state_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (month_r >= MON_JAN) && (month_r <= MON_DEC) && (day_r != 5'd0) &&
    (day_r <= month_len(month_r, leap_r)) && (year_r <= YEAR_LIM))
    else $error("stored date out of range");

  a_leap_track: assert property (@(posedge clk) disable iff (!rst_n)
    leap_r == leap_of(year_r))
    else $error("leap flag does not match stored year");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !ok_nxt |=> $stable(day_r) && $stable(month_r) && $stable(year_r))
    else $error("rejected item changed the stored date");

endmodule

// ===== rtl/cdw_year_split.sv =====
// cdw_year_split: two pipeline stages that split the year into century and year of century
// and form the weekday offset of the year; depends on cdw_pkg
module cdw_year_split (
  input  logic            clk,
  input  logic            rst_n,
  input  cdw_pkg::date_t  up_data,
  input  logic            up_valid,
  output logic            up_ready,
  output cdw_pkg::yinfo_t dn_data,
  output logic            dn_valid,
  input  logic            dn_ready
);
  import cdw_pkg::*;

  logic       s2_v_r, s3_v_r;
  split_t     s2_r;
  yinfo_t     s3_r;
  logic       s2_load, s3_load;

  split_t     s2_nxt;
  yinfo_t     s3_nxt;
  logic [25:0] prod;
  logic [6:0]  q100;
  logic [2:0]  yc;

  assign s3_load  = !s3_v_r || dn_ready;
  assign s2_load  = !s2_v_r || s3_load;
  assign up_ready = s2_load;
  assign dn_valid = s3_v_r;
  assign dn_data  = s3_r;

  // year / 100 by reciprocal, exact over the 13-bit range
  always_comb begin
    prod        = 26'(up_data.year) * 26'd5243;
    q100        = prod[25:19];
    s2_nxt.date = up_data;
    s2_nxt.yy   = 7'(up_data.year - 13'(14'(q100) * 14'd100));
    s2_nxt.cent = q100[1:0];
  end

  // previous year is leap: year = 1 mod 4, and not a century unless a 400th
  always_comb begin
    yc                = mod7(9'(s2_r.yy) + 9'(s2_r.yy[6:2]));
    s3_nxt.date       = s2_r.date;
    s3_nxt.yoff       = mod7(9'(yc) + 9'({2'd3 - s2_r.cent, 1'b0}) + 9'd6);
    s3_nxt.leap_prev  = (s2_r.date.year != 13'd0) && (s2_r.date.year[1:0] == 2'd1) &&
                        ((s2_r.yy != 7'd1) || (s2_r.cent == 2'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s2_load) begin
        s2_v_r <= up_valid;
      end
      if (s3_load) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && s2_load) begin
      s2_r <= s2_nxt;
    end
    if (s2_v_r && s3_load) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

// ===== rtl/cdw_week_calc.sv =====
// cdw_week_calc: weekday and iso week from the year offset, result register on the out channel
// depends on cdw_pkg and cdw_out_if
module cdw_week_calc (
  input  logic            clk,
  input  logic            rst_n,
  input  cdw_pkg::yinfo_t up_data,
  input  logic            up_valid,
  output logic            up_ready,
  cdw_out_if.source       out_ch
);
  import cdw_pkg::*;

  logic              out_v_r;
  date_t             date_r;
  logic [WDAY_W-1:0] wday_r, wday_nxt;
  logic [WEEK_W-1:0] week_r, week_nxt;

  date_t             d;
  logic [3:0]        midx;
  logic              lp_early, lp_late;
  logic [2:0]        j1, w4;
  logic [5:0]        k;
  logic [11:0]       kq;
  logic [WEEK_W-1:0] wk;
  logic              has53, prev53;

  assign up_ready = !out_v_r || out_ch.ready;

  always_comb begin
    d        = up_data.date;
    midx     = mix(d.month);
    lp_early = d.leap && (d.month < 4'd3);
    lp_late  = d.leap && (d.month > MON_FEB);
    wday_nxt = mod7(9'(d.day) + 9'(MONTH_SHIFT[midx]) + 9'd7 + 9'(up_data.yoff)
                    - 9'(lp_early)) + 3'd1;
    j1       = mod7(9'd8 + 9'(up_data.yoff) - 9'(d.leap)) + 3'd1;
    w4       = mod7(9'd11 + 9'(up_data.yoff) - 9'(d.leap));
    k        = 6'(w4) + 6'(MONTH_SHIFT[midx]) + 6'(d.day) + 6'd3 + 6'(lp_late);
    kq       = 12'(k) * 12'd37;
    wk       = 6'(kq[11:8]) + MONTH_WEEKS[midx];
    has53    = (j1 == 3'd4) || ((j1 == 3'd3) && d.leap);
    prev53   = (j1 == 3'd5) || ((j1 == 3'd6) && up_data.leap_prev);
    // early january belongs to the last week of the year before
    if (wk == 6'd0) begin
      week_nxt = prev53 ? 6'd53 : 6'd52;
    end else if (wk == 6'd53 && !has53) begin
      week_nxt = 6'd1;
    end else begin
      week_nxt = wk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (up_ready) begin
      out_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      date_r <= up_data.date;
      wday_r <= wday_nxt;
      week_r <= week_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.ok        = date_r.ok;
  assign out_ch.day_out   = date_r.day;
  assign out_ch.month_out = date_r.month;
  assign out_ch.year_out  = date_r.year;
  assign out_ch.leap_year = date_r.leap;
  assign out_ch.weekday   = wday_r;
  assign out_ch.iso_week  = week_r;

  a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (wday_r >= 3'd1) && (wday_r <= 3'd7))
    else $error("weekday out of range");

  a_week_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (week_r >= 6'd1) && (week_r <= 6'd53))
    else $error("iso week out of range");

  a_jan4_week1: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (date_r.month == MON_JAN) && (date_r.day == 5'd4) |-> (week_r == 6'd1))
    else $error("january 4 not in week 1");

endmodule

// ===== rtl/calendar_date_weekday_iso_week_core.sv =====
// calendar_date_weekday_iso_week_core: gregorian date keeper with weekday and iso week
// depends on cdw_pkg, cdw_in_if, cdw_out_if, cdw_date_step, cdw_year_split, cdw_week_calc
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   opcode, day_in, month_in, year_in
//   out_ch   out  valid/ready   ok, day_out, month_out, year_out, leap_year, weekday, iso_week
//
// one item per cycle sustained while out_ch is ready; each item's result is offered from the week/result register
// the stored date updates at the accepting edge, so items may follow each other back to back
// four registered stages (date step, year split, year offset, week/result) set the latency
// a stall on out_ch fills the stages and then drops in_ch.ready; nothing is lost
// reset (synchronous, active low) sets the date to 2000-01-01 and empties the pipeline
module calendar_date_weekday_iso_week_core #(
  parameter int unsigned MAX_YEAR = 7999
) (
  input  logic      clk,
  input  logic      rst_n,
  cdw_in_if.sink    in_ch,
  cdw_out_if.source out_ch
);
  import cdw_pkg::*;

  date_t  step_data;
  logic   step_valid, step_ready;
  yinfo_t yinfo_data;
  logic   yinfo_valid, yinfo_ready;

  cdw_date_step #(
    .MAX_YEAR (MAX_YEAR)
  ) u_date_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_data  (step_data),
    .dn_valid (step_valid),
    .dn_ready (step_ready)
  );

  cdw_year_split u_year_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_data  (step_data),
    .up_valid (step_valid),
    .up_ready (step_ready),
    .dn_data  (yinfo_data),
    .dn_valid (yinfo_valid),
    .dn_ready (yinfo_ready)
  );

  cdw_week_calc u_week_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_data  (yinfo_data),
    .up_valid (yinfo_valid),
    .up_ready (yinfo_ready),
    .out_ch   (out_ch)
  );

endmodule

// ===== dv/cdw_date_checker.sv =====
// cdw_date_checker: watches the command and result channels of the date core,
// predicts each result from its own calendar arithmetic and compares field by field
// depends on cdw_pkg, cdw_in_if and cdw_out_if
module cdw_date_checker #(
  parameter int unsigned LAST_YEAR = 7999
) (
  input  logic clk,
  input  logic rst_n,
  cdw_in_if    in_mon,
  cdw_out_if   out_mon,
  output int   errors,
  output int   waiting
);
  import cdw_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic              leap;
    logic [WDAY_W-1:0] wday;
    logic [WEEK_W-1:0] week;
  } date_report_t;

  localparam int unsigned SHIFT_TBL [12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
  localparam int unsigned DAYS_TBL  [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned WEEKS_TBL [12] = '{0, 4, 8, 12, 17, 21, 25, 30, 34, 39, 43, 47};

  int unsigned  cur_day;
  int unsigned  cur_month;
  int unsigned  cur_year;
  date_report_t date_q[$];

  function automatic int unsigned month_idx(input int unsigned m);
    return (m >= 1 && m <= 12) ? m - 1 : 0;
  endfunction

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    int unsigned n;
    n = DAYS_TBL[month_idx(m)];
    if (m == 2 && is_leap(y)) begin
      n = 29;
    end
    return n;
  endfunction

  function automatic int unsigned day_of_week(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
    int unsigned yy;
    int unsigned c;
    int unsigned w;
    yy = y % 100;
    c  = (y / 100) % 4;
    w  = d + SHIFT_TBL[month_idx(m)] + 7;
    if (m < 3 && is_leap(y)) begin
      w = w - 1;
    end
    w = w + (yy + yy / 4) % 7;
    w = w + (3 - c) * 2;
    w = w + 6;
    return w % 7 + 1;
  endfunction

  function automatic int unsigned week_of_year(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
    int unsigned jan4;
    int unsigned jan1;
    int unsigned k;
    int unsigned wk;
    bit          long_prev;
    jan4 = day_of_week(4, 1, y) - 1;
    jan1 = day_of_week(1, 1, y);
    k    = jan4 + SHIFT_TBL[month_idx(m)] + d + 3;
    if (m > 2 && is_leap(y)) begin
      k = k + 1;
    end
    wk = k / 7 + WEEKS_TBL[month_idx(m)];
    if (wk == 0) begin
      // early january belongs to the last week of the year before; year -1 is common
      long_prev = (jan1 == 5) || (jan1 == 6 && y > 0 && is_leap(y - 1));
      wk = long_prev ? 53 : 52;
    end else if (wk == 53 && !(jan1 == 4 || (jan1 == 3 && is_leap(y)))) begin
      wk = 1;
    end
    return wk;
  endfunction

  function automatic date_report_t apply_command(input logic [OP_W-1:0] op,
                                                 input int unsigned d, input int unsigned m,
                                                 input int unsigned y);
    date_report_t r;
    logic         done;
    done = 1'b0;
    case (op)
      OP_LOAD: begin
        if (m >= 1 && m <= 12 && y <= LAST_YEAR && d >= 1 && d <= days_in(m, y)) begin
          cur_day   = d;
          cur_month = m;
          cur_year  = y;
          done      = 1'b1;
        end
      end
      OP_FWD: begin
        done = 1'b1;
        if (cur_day < days_in(cur_month, cur_year)) begin
          cur_day = cur_day + 1;
        end else if (cur_month < 12) begin
          cur_day   = 1;
          cur_month = cur_month + 1;
        end else if (cur_year < LAST_YEAR) begin
          cur_day   = 1;
          cur_month = 1;
          cur_year  = cur_year + 1;
        end else begin
          done = 1'b0;
        end
      end
      OP_BACK: begin
        done = 1'b1;
        if (cur_day > 1) begin
          cur_day = cur_day - 1;
        end else if (cur_month > 1) begin
          cur_month = cur_month - 1;
          cur_day   = days_in(cur_month, cur_year);
        end else if (cur_year > 0) begin
          cur_year  = cur_year - 1;
          cur_month = 12;
          cur_day   = 31;
        end else begin
          done = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.ok    = done;
    r.day   = DAY_W'(cur_day);
    r.month = MON_W'(cur_month);
    r.year  = YEAR_W'(cur_year);
    r.leap  = is_leap(cur_year);
    r.wday  = WDAY_W'(day_of_week(cur_day, cur_month, cur_year));
    r.week  = WEEK_W'(week_of_year(cur_day, cur_month, cur_year));
    return r;
  endfunction

  task automatic report(input string msg);
    if (errors < 40) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    errors = errors + 1;
  endtask

  always @(posedge clk) begin : watch
    date_report_t got;
    date_report_t want;
    if (!rst_n) begin
      cur_day   = 1;
      cur_month = 1;
      cur_year  = 2000;
      date_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.ok, out_mon.day_out, out_mon.month_out, out_mon.year_out,
                out_mon.leap_year, out_mon.weekday, out_mon.iso_week};
        if (date_q.size() == 0) begin
          report($sformatf("result with nothing outstanding: %p", got));
        end else begin
          want = date_q.pop_front();
          if (got.ok !== want.ok)
            report($sformatf("ok got %0d want %0d", got.ok, want.ok));
          if (got.day !== want.day)
            report($sformatf("day got %0d want %0d", got.day, want.day));
          if (got.month !== want.month)
            report($sformatf("month got %0d want %0d", got.month, want.month));
          if (got.year !== want.year)
            report($sformatf("year got %0d want %0d", got.year, want.year));
          if (got.leap !== want.leap)
            report($sformatf("leap got %0d want %0d", got.leap, want.leap));
          if (got.wday !== want.wday)
            report($sformatf("weekday got %0d want %0d", got.wday, want.wday));
          if (got.week !== want.week)
            report($sformatf("iso week got %0d want %0d (date %0d-%0d-%0d)",
                             got.week, want.week, want.year, want.month, want.day));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        date_q.push_back(apply_command(in_mon.opcode, 32'(in_mon.day_in),
                                       32'(in_mon.month_in), 32'(in_mon.year_in)));
      end
    end
    waiting = date_q.size();
  end

endmodule

// ===== dv/tb_calendar_date_weekday_iso_week_core.sv =====
// tb_calendar_date_weekday_iso_week_core: drives directed and random date commands into
// the core with random gaps and result stalls, and gives the verdict from the checker
// depends on cdw_pkg, cdw_in_if, cdw_out_if, cdw_date_checker and the core
module tb_calendar_date_weekday_iso_week_core;
  import cdw_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int              ITEM_COUNT  = 1775;
  localparam int              CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  int   sent;
  int   cycle_count;
  int   fail_count;
  int   waiting;

  cdw_in_if  in_ch ();
  cdw_out_if out_ch ();

  calendar_date_weekday_iso_week_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cdw_date_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .errors  (fail_count),
    .waiting (waiting)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_calendar_date_weekday_iso_week_core: FAIL");
      $finish;
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input int unsigned d, input int unsigned m,
                      input int unsigned y);
    while (!steady && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.day_in   <= DAY_W'(d);
    in_ch.month_in <= MON_W'(m);
    in_ch.year_in  <= YEAR_W'(y);
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    sent = sent + 1;
  endtask

  task automatic load(input int unsigned d, input int unsigned m, input int unsigned y);
    send(OP_LOAD, d, m, y);
  endtask

  // valid date load followed by a run of day steps, mostly in one direction
  task automatic walk_dates();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned steps;
    int unsigned fwd_bias;
    case ($urandom_range(0, 9))
      0:       y = 0;
      1:       y = 7999;
      2:       y = $urandom_range(0, 79) * 100;
      3:       y = $urandom_range(0, 7999) & ~32'd3;
      default: y = $urandom_range(0, 7999);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: m = 1;
      3, 4:    m = 2;
      5, 6:    m = 12;
      default: m = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 3))
      0:       d = 1;
      1:       d = $urandom_range(26, 28);
      default: d = $urandom_range(1, 28);
    endcase
    load(d, m, y);
    steps    = $urandom_range(1, 12);
    fwd_bias = $urandom_range(0, 1) ? 85 : 15;
    repeat (steps) begin
      send($urandom_range(0, 99) < fwd_bias ? OP_FWD : OP_BACK, $urandom, $urandom, $urandom);
    end
  endtask

  // loads aimed at the validation rules
  task automatic bad_load();
    case ($urandom_range(0, 3))
      0: load($urandom_range(0, 31), $urandom_range(0, 1) ? 0 : $urandom_range(13, 15),
              $urandom_range(0, 8191));
      1: load($urandom_range(1, 28), $urandom_range(1, 12), $urandom_range(8000, 8191));
      2: load(0, $urandom_range(1, 12), $urandom_range(0, 7999));
      default: load($urandom_range(29, 31), $urandom_range(1, 12), $urandom_range(0, 8191));
    endcase
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_LOAD;
    in_ch.day_in   <= '0;
    in_ch.month_in <= '0;
    in_ch.year_in  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_UNUSED, 31, 15, 8191);
    load(0, 0, 0);
    load(1, 1, 0);
    send(OP_BACK, 0, 0, 0);
    send(OP_FWD, 0, 0, 0);
    load(31, 12, 7999);
    send(OP_FWD, 0, 0, 0);
    send(OP_BACK, 0, 0, 0);
    load(1, 13, 2020);
    load(1, 1, 8000);
    load(29, 2, 1900);
    load(29, 2, 2000);
    send(OP_FWD, 0, 0, 0);
    send(OP_BACK, 0, 0, 0);
    load(31, 4, 2021);
    load(1, 3, 2023);
    send(OP_BACK, 0, 0, 0);
    load(1, 1, 2021);
    load(1, 1, 2010);
    load(31, 12, 2024);
    load(1, 1, 2001);
    send(OP_BACK, 0, 0, 0);

    while (sent < ITEM_COUNT) begin
      steady = (sent >= 800 && sent < 1100);
      case ($urandom_range(0, 9))
        0, 1: send(OP_W'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 15),
                   $urandom_range(0, 8191));
        2:    bad_load();
        default: walk_dates();
      endcase
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_calendar_date_weekday_iso_week_core: PASS");
    end else begin
      $display("tb_calendar_date_weekday_iso_week_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cdw_pkg.sv
rtl/cdw_in_if.sv
rtl/cdw_out_if.sv
rtl/cdw_date_step.sv
rtl/cdw_year_split.sv
rtl/cdw_week_calc.sv
rtl/calendar_date_weekday_iso_week_core.sv
dv/cdw_date_checker.sv
dv/tb_calendar_date_weekday_iso_week_core.sv
